@@ rtl/core/pdjm_pkg.sv @@
// Shared types, constants and arithmetic helpers for the packet delay and jitter monitor.
package pdjm_pkg;

	localparam int TIME_W  = 48;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;

	localparam logic [7:0]  MEASURE_START_SEQ = 8'd3;
	localparam logic [16:0] LOSS_SCALE        = 17'd100000;
	localparam logic [6:0]  PCT_SCALE         = 7'd100;

	localparam logic [15:0] DELAY_LIMIT_RST    = 16'd500;
	localparam logic [15:0] IPDV_LIMIT_RST     = 16'd500;
	localparam logic [6:0]  EXCEED_PCT_RST     = 7'd1;
	localparam logic [6:0]  LOSS_PCT_RST       = 7'd1;
	localparam logic [15:0] NOMINAL_PERIOD_RST = 16'd1000;

	typedef enum logic [CIDX_W-1:0] {
		REG_DELAY_LIMIT    = 3'd0,
		REG_IPDV_LIMIT     = 3'd1,
		REG_EXCEED_PCT     = 3'd2,
		REG_LOSS_PCT       = 3'd3,
		REG_NOMINAL_PERIOD = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_PASS = 2'd0,
		VERDICT_WARN = 2'd1,
		VERDICT_FAIL = 2'd2,
		VERDICT_NONE = 2'd3
	} verdict_t;

	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	typedef struct packed {
		logic              func;
		logic [7:0]        seq_number;
		logic [TIME_W-1:0] arrival_time_ms;
		logic [TIME_W-1:0] send_time_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] current_delay;
		logic [30:0]        largest_delay;
		logic signed [31:0] smallest_ipdv;
		logic [30:0]        largest_ipdv;
		logic [30:0]        largest_jitter;
		logic [31:0]        delay_excess_count;
		logic [31:0]        ipdv_excess_count;
		logic [31:0]        counted_packets;
		logic signed [47:0] delay_total;
		logic signed [47:0] ipdv_total;
		logic [46:0]        jitter_total;
		logic [1:0]         verdict;
	} out_item_t;

	typedef struct packed {
		logic [15:0] delay_limit;
		logic [15:0] ipdv_limit;
		logic [6:0]  exceed_pct;
		logic [6:0]  loss_pct;
		logic [15:0] nominal_period;
	} cfg_t;

	// item after delay / IPDV formation
	typedef struct packed {
		logic               func;
		logic               measured;
		logic               run_start;
		logic [TIME_W-1:0]  arrival;
		logic signed [31:0] delay;
		logic signed [31:0] ipdv;
	} pkt_t;

	// saturate a 50-bit two's complement value to 32 bits
	function automatic logic signed [31:0] sat32(input logic [49:0] x);
		logic signed [31:0] r;
		if (x[49:31] == {19{x[49]}})
			r = x[31:0];
		else if (x[49])
			r = 32'sh8000_0000;
		else
			r = 32'sh7FFF_FFFF;
		return r;
	endfunction

	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		logic [31:0] a;
		logic [30:0] r;
		a = v[31] ? 32'(-v) : 32'(v);
		r = a[31] ? '1 : a[30:0];
		return r;
	endfunction

	function automatic logic signed [47:0] add48sat(input logic signed [47:0] acc,
		input logic signed [31:0] v);
		logic signed [48:0] s;
		logic signed [47:0] r;
		s = {acc[47], acc} + {{17{v[31]}}, v};
		if (s[48] != s[47])
			r = s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		else
			r = s[47:0];
		return r;
	endfunction

	function automatic logic [31:0] inc32sat(input logic [31:0] c);
		logic [31:0] r;
		r = (c == '1) ? c : c + 32'd1;
		return r;
	endfunction

endpackage

@@ rtl/core/pdjm_stats.sv @@
// Running statistics: extremes, excess counters and saturating sums of measured packets.
module pdjm_stats (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  pdjm_pkg::pkt_t     pkt,
	input  pdjm_pkg::cfg_t     cfg,
	output pdjm_pkg::out_item_t res,
	output logic signed [48:0] runtime
);
	import pdjm_pkg::*;

	logic [TIME_W-1:0]  run_start_q, run_start_n;
	logic [30:0]        max_delay_q, max_delay_n;
	logic signed [31:0] min_var_q, min_var_n;
	logic [30:0]        max_var_q, max_var_n;
	logic [30:0]        max_jit_q, max_jit_n;
	logic [31:0]        delay_cnt_q, delay_cnt_n;
	logic [31:0]        var_cnt_q, var_cnt_n;
	logic [31:0]        meas_cnt_q, meas_cnt_n;
	logic signed [47:0] delay_acc_q, delay_acc_n;
	logic signed [47:0] var_acc_q, var_acc_n;
	logic [46:0]        jit_acc_q, jit_acc_n;
	logic [30:0]        ad, av;
	logic [47:0]        jit_sum;

	always_comb begin
		ad          = mag31(pkt.delay);
		av          = mag31(pkt.ipdv);
		jit_sum     = {1'b0, jit_acc_q} + {17'b0, av};
		run_start_n = run_start_q;
		max_delay_n = max_delay_q;
		min_var_n   = min_var_q;
		max_var_n   = max_var_q;
		max_jit_n   = max_jit_q;
		delay_cnt_n = delay_cnt_q;
		var_cnt_n   = var_cnt_q;
		meas_cnt_n  = meas_cnt_q;
		delay_acc_n = delay_acc_q;
		var_acc_n   = var_acc_q;
		jit_acc_n   = jit_acc_q;
		if (pkt.func == FUNC_PACKET && pkt.measured) begin
			if (pkt.run_start)
				run_start_n = pkt.arrival;
			if (!pkt.ipdv[31] && pkt.ipdv[30:0] > max_var_q)
				max_var_n = pkt.ipdv[30:0];
			if (pkt.ipdv < min_var_q)
				min_var_n = pkt.ipdv;
			if (av > max_jit_q)
				max_jit_n = av;
			if (ad > max_delay_q)
				max_delay_n = ad;
			if (av > {15'b0, cfg.ipdv_limit})
				var_cnt_n = inc32sat(var_cnt_q);
			if (ad > {15'b0, cfg.delay_limit})
				delay_cnt_n = inc32sat(delay_cnt_q);
			var_acc_n   = add48sat(var_acc_q, pkt.ipdv);
			jit_acc_n   = jit_sum[47] ? '1 : jit_sum[46:0];
			meas_cnt_n  = inc32sat(meas_cnt_q);
			delay_acc_n = add48sat(delay_acc_q, pkt.delay);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= '0;
			max_delay_q <= '0;
			min_var_q   <= '0;
			max_var_q   <= '0;
			max_jit_q   <= '0;
			delay_cnt_q <= '0;
			var_cnt_q   <= '0;
			meas_cnt_q  <= '0;
			delay_acc_q <= '0;
			var_acc_q   <= '0;
			jit_acc_q   <= '0;
		end else if (upd) begin
			run_start_q <= run_start_n;
			max_delay_q <= max_delay_n;
			min_var_q   <= min_var_n;
			max_var_q   <= max_var_n;
			max_jit_q   <= max_jit_n;
			delay_cnt_q <= delay_cnt_n;
			var_cnt_q   <= var_cnt_n;
			meas_cnt_q  <= meas_cnt_n;
			delay_acc_q <= delay_acc_n;
			var_acc_q   <= var_acc_n;
			jit_acc_q   <= jit_acc_n;
		end
	end

	assign runtime = $signed({1'b0, pkt.arrival}) - $signed({1'b0, run_start_q});

	always_comb begin
		res.current_delay      = (pkt.func == FUNC_REPORT) ? 32'sd0 : pkt.delay;
		res.largest_delay      = max_delay_n;
		res.smallest_ipdv      = min_var_n;
		res.largest_ipdv       = max_var_n;
		res.largest_jitter     = max_jit_n;
		res.delay_excess_count = delay_cnt_n;
		res.ipdv_excess_count  = var_cnt_n;
		res.counted_packets    = meas_cnt_n;
		res.delay_total        = delay_acc_n;
		res.ipdv_total         = var_acc_n;
		res.jitter_total       = jit_acc_n;
		res.verdict            = VERDICT_NONE;
	end

endmodule

@@ rtl/core/pdjm_judge.sv @@
// Report verdict: loss and excess-percentage tests by integer cross-multiplication.
module pdjm_judge (
	input  logic                clk,
	input  logic                ld,
	input  pdjm_pkg::out_item_t res,
	input  logic signed [48:0]  runtime,
	input  pdjm_pkg::cfg_t      cfg,
	output logic [1:0]          verdict
);
	import pdjm_pkg::*;

	logic signed [7:0]  loss_k;
	logic signed [56:0] lhs_c;
	logic [48:0]        need_c;
	logic [38:0]        dpct_c, vpct_c, limm_c;
	logic               rt_pos_c;

	logic signed [56:0] lhs_s4;
	logic [48:0]        need_s4;
	logic [38:0]        dpct_s4, vpct_s4, limm_s4;
	logic               rt_pos_s4, mzero_s4, dzero_s4, vzero_s4;

	logic               loss_over, loss_under, dpct_over, vpct_over;

	always_comb begin
		loss_k   = $signed({1'b0, PCT_SCALE}) - $signed({1'b0, cfg.loss_pct});
		lhs_c    = $signed({{49{loss_k[7]}}, loss_k}) * $signed({{8{runtime[48]}}, runtime});
		need_c   = {17'b0, res.counted_packets} * {32'b0, LOSS_SCALE};
		dpct_c   = {7'b0, res.delay_excess_count} * {32'b0, PCT_SCALE};
		vpct_c   = {7'b0, res.ipdv_excess_count} * {32'b0, PCT_SCALE};
		limm_c   = {32'b0, cfg.exceed_pct} * {7'b0, res.counted_packets};
		rt_pos_c = !runtime[48] && (runtime != '0);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			lhs_s4    <= lhs_c;
			need_s4   <= need_c;
			dpct_s4   <= dpct_c;
			vpct_s4   <= vpct_c;
			limm_s4   <= limm_c;
			rt_pos_s4 <= rt_pos_c;
			mzero_s4  <= (res.counted_packets == '0);
			dzero_s4  <= (res.delay_excess_count == '0);
			vzero_s4  <= (res.ipdv_excess_count == '0);
		end
	end

	always_comb begin
		loss_over  = rt_pos_s4 && (lhs_s4 > $signed({8'b0, need_s4}));
		loss_under = (cfg.loss_pct != '0) &&
			(!rt_pos_s4 || (lhs_s4 < $signed({8'b0, need_s4})));
		dpct_over  = !mzero_s4 && (dpct_s4 > limm_s4);
		vpct_over  = !mzero_s4 && (vpct_s4 > limm_s4);
		priority if (loss_over || dpct_over || vpct_over)
			verdict = VERDICT_FAIL;
		else if (loss_under && dzero_s4 && vzero_s4)
			verdict = VERDICT_PASS;
		else
			verdict = VERDICT_WARN;
	end

endmodule

@@ rtl/core/packet_delay_jitter_monitor.sv @@
// Top level of the packet delay and jitter monitor: config registers, pipeline and handshakes.
// Pipeline: five register stages: input, delay/IPDV, statistics, products, output.
// Throughput: one item per cycle while out_ready is high; each stage advances when
// the one after it is empty or moving, so a stalled output back-pressures the stages before it.
// Reset: all statistics and previous-arrival state clear, config registers take their defaults,
// the pipeline empties; no clearing pass is needed.
module packet_delay_jitter_monitor (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [pdjm_pkg::CIDX_W-1:0] cfg_idx,
	input  logic [pdjm_pkg::CFG_W-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pdjm_pkg::in_item_t       in_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pdjm_pkg::out_item_t      out_item
);
	import pdjm_pkg::*;

	cfg_t               cfg_q;
	logic [TIME_W-1:0]  prev_arr_q;
	logic               have_prev_q;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               rdy1, rdy2, rdy3, rdy4, rdy5;
	in_item_t           item_s1;
	pkt_t               pkt_c, pkt_s2;
	out_item_t          res_c, res_s3, res_s4, out_c, out_s5;
	logic signed [48:0] rt_c, rt_s3;
	logic               rep_s3, rep_s4;
	logic [1:0]         judge_verdict;
	logic [TIME_W-1:0]  prev_arr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_limit    <= DELAY_LIMIT_RST;
			cfg_q.ipdv_limit     <= IPDV_LIMIT_RST;
			cfg_q.exceed_pct     <= EXCEED_PCT_RST;
			cfg_q.loss_pct       <= LOSS_PCT_RST;
			cfg_q.nominal_period <= NOMINAL_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DELAY_LIMIT:    cfg_q.delay_limit    <= cfg_data;
				REG_IPDV_LIMIT:     cfg_q.ipdv_limit     <= cfg_data;
				REG_EXCEED_PCT:     cfg_q.exceed_pct     <= cfg_data[6:0];
				REG_LOSS_PCT:       cfg_q.loss_pct       <= cfg_data[6:0];
				REG_NOMINAL_PERIOD: cfg_q.nominal_period <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: delay and IPDV
	assign prev_arr = have_prev_q ? prev_arr_q : item_s1.arrival_time_ms;

	always_comb begin
		pkt_c.func      = item_s1.func;
		pkt_c.measured  = (item_s1.seq_number >= MEASURE_START_SEQ);
		pkt_c.run_start = (item_s1.seq_number == MEASURE_START_SEQ);
		pkt_c.arrival   = item_s1.arrival_time_ms;
		pkt_c.delay     = sat32({2'b0, item_s1.arrival_time_ms} - {2'b0, item_s1.send_time_ms});
		pkt_c.ipdv      = sat32({2'b0, item_s1.arrival_time_ms} - {2'b0, prev_arr}
			- {34'b0, cfg_q.nominal_period});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_arr_q  <= '0;
			have_prev_q <= 1'b0;
		end else if (v_s1 && rdy2 && item_s1.func == FUNC_PACKET) begin
			prev_arr_q  <= item_s1.arrival_time_ms;
			have_prev_q <= 1'b1;
		end
	end

	// stage 2: statistics update
	pdjm_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (v_s2 && rdy3),
		.pkt     (pkt_s2),
		.cfg     (cfg_q),
		.res     (res_c),
		.runtime (rt_c)
	);

	// stages 3 and 4: report verdict
	pdjm_judge u_judge (
		.clk     (clk),
		.ld      (v_s3 && rdy4),
		.res     (res_s3),
		.runtime (rt_s3),
		.cfg     (cfg_q),
		.verdict (judge_verdict)
	);

	always_comb begin
		out_c         = res_s4;
		out_c.verdict = rep_s4 ? judge_verdict : VERDICT_NONE;
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1)
			item_s1 <= in_item;
		if (v_s1 && rdy2)
			pkt_s2 <= pkt_c;
		if (v_s2 && rdy3) begin
			res_s3 <= res_c;
			rt_s3  <= rt_c;
			rep_s3 <= (pkt_s2.func == FUNC_REPORT);
		end
		if (v_s3 && rdy4) begin
			res_s4 <= res_s3;
			rep_s4 <= rep_s3;
		end
		if (v_s4 && rdy5)
			out_s5 <= out_c;
	end

	assign out_valid = v_s5;
	assign out_item  = out_s5;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy3) |=> (v_s2 && $stable(pkt_s2)))
		else $error("stalled stage 2 item changed");

	a_min_ipdv_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.smallest_ipdv[31] || out_item.smallest_ipdv == 32'sd0))
		else $error("smallest IPDV positive");

	a_jitter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.largest_jitter >= out_item.largest_ipdv))
		else $error("largest jitter below largest IPDV");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.delay_excess_count <= out_item.counted_packets &&
			out_item.ipdv_excess_count <= out_item.counted_packets))
		else $error("excess count above measured count");

endmodule

@@ bench/pdjm_result_check.sv @@
// Result checker for the packet delay and jitter monitor: predicts each result item and compares.
module pdjm_result_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pdjm_pkg::CIDX_W-1:0] cfg_idx,
	input  logic [pdjm_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  pdjm_pkg::in_item_t          in_item,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  pdjm_pkg::out_item_t         out_item,
	output int                          errors,
	output int                          outstanding
);
	import pdjm_pkg::*;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint S48_MIN = -64'sh8000_0000_0000;
	localparam longint U47_MAX = 64'sh7FFF_FFFF_FFFF;

	cfg_t               cfg;
	logic [TIME_W-1:0]  prev_arrival;
	logic               have_prev;
	logic [TIME_W-1:0]  run_start;
	logic [30:0]        max_delay;
	logic signed [31:0] min_ipdv;
	logic [30:0]        peak_ipdv;
	logic [30:0]        max_jitter;
	logic [31:0]        delay_over;
	logic [31:0]        ipdv_over;
	logic [31:0]        measured;
	logic signed [47:0] delay_sum;
	logic signed [47:0] ipdv_sum;
	logic [46:0]        jitter_sum;

	out_item_t results_due[$];
	out_item_t want;

	function automatic logic signed [31:0] to_s32(input longint v);
		if (v > S32_MAX)
			return 32'sh7FFF_FFFF;
		if (v < S32_MIN)
			return 32'sh8000_0000;
		return 32'(v);
	endfunction

	function automatic logic [30:0] magnitude(input logic signed [31:0] v);
		longint a;
		a = v;
		if (a < 0)
			a = -a;
		if (a > S32_MAX)
			a = S32_MAX;
		return a[30:0];
	endfunction

	function automatic logic signed [47:0] sum48(input logic signed [47:0] acc,
		input logic signed [31:0] v);
		longint s;
		s = longint'(acc) + longint'(v);
		if (s > S48_MAX)
			s = S48_MAX;
		else if (s < S48_MIN)
			s = S48_MIN;
		return s[47:0];
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	function automatic bit share_over(input logic [31:0] c);
		if (measured == 32'd0)
			return 1'b0;
		return longint'(c) * 100 > longint'(cfg.exceed_pct) * longint'(measured);
	endfunction

	// loss > limit  <=>  (100 - limit) * runtime > 100000 * measured
	function automatic verdict_t grade(input logic [TIME_W-1:0] now);
		longint span;
		longint lim;
		longint lhs;
		longint need;
		bit over;
		bit under;
		span = longint'(now) - longint'(run_start);
		lim = longint'(cfg.loss_pct);
		need = longint'(measured) * 100000;
		if (span <= 0) begin
			over = 1'b0;
			under = lim > 0;
		end else begin
			lhs = (100 - lim) * span;
			over = lhs > need;
			under = lim > 0 && lhs < need;
		end
		if (over || share_over(delay_over) || share_over(ipdv_over))
			return VERDICT_FAIL;
		if (under && delay_over == 32'd0 && ipdv_over == 32'd0)
			return VERDICT_PASS;
		return VERDICT_WARN;
	endfunction

	function automatic out_item_t monitor_update(input in_item_t it);
		out_item_t r;
		longint arr;
		longint snd;
		longint prv;
		longint js;
		logic signed [31:0] dly;
		logic signed [31:0] ipdv;
		logic [30:0] ad;
		logic [30:0] av;
		verdict_t v;
		arr = it.arrival_time_ms;
		snd = it.send_time_ms;
		dly = '0;
		v = VERDICT_NONE;
		if (it.func == FUNC_REPORT) begin
			v = grade(it.arrival_time_ms);
		end else begin
			if (have_prev)
				prv = prev_arrival;
			else
				prv = arr;
			dly = to_s32(arr - snd);
			ipdv = to_s32(arr - prv - longint'(cfg.nominal_period));
			if (it.seq_number >= MEASURE_START_SEQ) begin
				ad = magnitude(dly);
				av = magnitude(ipdv);
				if (it.seq_number == MEASURE_START_SEQ)
					run_start = it.arrival_time_ms;
				if (ipdv > 0 && ipdv[30:0] > peak_ipdv)
					peak_ipdv = ipdv[30:0];
				if (ipdv < min_ipdv)
					min_ipdv = ipdv;
				if (av > max_jitter)
					max_jitter = av;
				if (ad > max_delay)
					max_delay = ad;
				if (av > cfg.ipdv_limit)
					ipdv_over = bump(ipdv_over);
				if (ad > cfg.delay_limit)
					delay_over = bump(delay_over);
				ipdv_sum = sum48(ipdv_sum, ipdv);
				js = longint'(jitter_sum) + longint'(av);
				if (js > U47_MAX)
					js = U47_MAX;
				jitter_sum = js[46:0];
				measured = bump(measured);
				delay_sum = sum48(delay_sum, dly);
			end
			prev_arrival = it.arrival_time_ms;
			have_prev = 1'b1;
		end
		r.current_delay = dly;
		r.largest_delay = max_delay;
		r.smallest_ipdv = min_ipdv;
		r.largest_ipdv = peak_ipdv;
		r.largest_jitter = max_jitter;
		r.delay_excess_count = delay_over;
		r.ipdv_excess_count = ipdv_over;
		r.counted_packets = measured;
		r.delay_total = delay_sum;
		r.ipdv_total = ipdv_sum;
		r.jitter_total = jitter_sum;
		r.verdict = v;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.delay_limit = DELAY_LIMIT_RST;
			cfg.ipdv_limit = IPDV_LIMIT_RST;
			cfg.exceed_pct = EXCEED_PCT_RST;
			cfg.loss_pct = LOSS_PCT_RST;
			cfg.nominal_period = NOMINAL_PERIOD_RST;
			prev_arrival = '0;
			have_prev = 1'b0;
			run_start = '0;
			max_delay = '0;
			min_ipdv = '0;
			peak_ipdv = '0;
			max_jitter = '0;
			delay_over = '0;
			ipdv_over = '0;
			measured = '0;
			delay_sum = '0;
			ipdv_sum = '0;
			jitter_sum = '0;
			results_due.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: result item with none outstanding, actual %h",
						$time, out_item);
				end else begin
					want = results_due.pop_front();
					check_field("current_delay", want.current_delay, out_item.current_delay);
					check_field("largest_delay", want.largest_delay, out_item.largest_delay);
					check_field("smallest_ipdv", want.smallest_ipdv, out_item.smallest_ipdv);
					check_field("largest_ipdv", want.largest_ipdv, out_item.largest_ipdv);
					check_field("largest_jitter", want.largest_jitter, out_item.largest_jitter);
					check_field("delay_excess_count", want.delay_excess_count,
						out_item.delay_excess_count);
					check_field("ipdv_excess_count", want.ipdv_excess_count,
						out_item.ipdv_excess_count);
					check_field("counted_packets", want.counted_packets,
						out_item.counted_packets);
					check_field("delay_total", want.delay_total, out_item.delay_total);
					check_field("ipdv_total", want.ipdv_total, out_item.ipdv_total);
					check_field("jitter_total", want.jitter_total, out_item.jitter_total);
					check_field("verdict", want.verdict, out_item.verdict);
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_DELAY_LIMIT: cfg.delay_limit = cfg_data;
					REG_IPDV_LIMIT: cfg.ipdv_limit = cfg_data;
					REG_EXCEED_PCT: cfg.exceed_pct = cfg_data[6:0];
					REG_LOSS_PCT: cfg.loss_pct = cfg_data[6:0];
					REG_NOMINAL_PERIOD: cfg.nominal_period = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				results_due.push_back(monitor_update(in_item));
			outstanding = results_due.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the packet delay and jitter monitor: clock, reset, stimulus and verdict.
module tb_top;
	import pdjm_pkg::*;

	localparam int TOTAL_ITEMS = 1450;
	localparam int IDLE_LIMIT  = 4000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	in_item_t          in_item;
	logic              out_valid;
	logic              out_ready;
	out_item_t         out_item;
	int                errors;
	int                outstanding;

	int sent_count = 0;
	int burst_left = 0;
	int cur_period = 1000;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	packet_delay_jitter_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	pdjm_result_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.errors      (errors),
		.outstanding (outstanding)
	);

	function automatic in_item_t item_of(input logic f, input logic [7:0] s,
		input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] t);
		in_item_t it;
		it.func = f;
		it.seq_number = s;
		it.arrival_time_ms = a;
		it.send_time_ms = t;
		return it;
	endfunction

	function automatic logic [TIME_W-1:0] rand48();
		return {16'($urandom()), $urandom()};
	endfunction

	// called at a rising edge; returns at the edge where the item is taken, or after the idle gap that ends a burst
	task automatic send_item(input in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_item <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sent_count++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] dl, input logic [15:0] il,
		input logic [6:0] ep, input logic [6:0] lp, input logic [15:0] np);
		write_reg(REG_DELAY_LIMIT, dl);
		write_reg(REG_IPDV_LIMIT, il);
		write_reg(REG_EXCEED_PCT, CFG_W'(ep));
		write_reg(REG_LOSS_PCT, CFG_W'(lp));
		write_reg(REG_NOMINAL_PERIOD, np);
		cfg_we <= 1'b0;
		cur_period = np;
	endtask

	// one telemetry stream: mostly periodic packets, some reports, some noise
	task automatic run_session(input int n);
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] stamp;
		logic [7:0] seq;
		longint jit;
		int roll;
		t = ($urandom_range(0, 7) == 0) ? rand48() : TIME_W'($urandom_range(0, 10000000));
		seq = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(240, 255)) : 8'd0;
		for (int i = 0; i < n && sent_count < TOTAL_ITEMS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_item(item_of(1'($urandom()), 8'($urandom()), rand48(), rand48()));
			end else if (roll < 18) begin
				case ($urandom_range(0, 3))
					0: stamp = t - TIME_W'($urandom_range(0, 5000));
					1: stamp = t + TIME_W'($urandom_range(0, 3000));
					2: stamp = t + TIME_W'($urandom_range(0, 50000000));
					default: stamp = rand48();
				endcase
				send_item(item_of(FUNC_REPORT, 8'($urandom()), stamp, rand48()));
			end else begin
				case ($urandom_range(0, 9))
					0: jit = longint'($urandom_range(0, 200000)) - 100000;
					1: jit = 0;
					default: jit = longint'($urandom_range(0, 1000)) - 500;
				endcase
				t = t + TIME_W'(longint'(cur_period) + jit);
				case ($urandom_range(0, 19))
					0: stamp = rand48();
					1, 2: stamp = t + TIME_W'($urandom_range(0, 300));
					default: stamp = t - TIME_W'($urandom_range(0, 800));
				endcase
				if ($urandom_range(0, 19) == 0)
					seq = seq + 8'($urandom_range(1, 4));
				send_item(item_of(FUNC_PACKET, seq, t, stamp));
				seq = seq + 8'd1;
			end
		end
	endtask

	// receiver: own stall pattern plus a long periodic hold
	initial begin
		int unsigned cyc;
		out_ready = 1'b0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 3000 >= 1500 && cyc % 3000 < 1800) begin
				out_ready <= 1'b0;
			end else begin
				case ((cyc / 250) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= cyc[1];
				endcase
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
				idle = 0;
			else
				idle++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int phase;
		logic [15:0] dl;
		logic [15:0] il;
		logic [6:0] ep;
		logic [6:0] lp;
		logic [15:0] np;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_DELAY_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reports with nothing measured: runtime zero, then positive
		send_item(item_of(FUNC_REPORT, 8'd0, 48'd0, 48'd0));
		send_item(item_of(FUNC_REPORT, 8'd0, 48'd1500, 48'd0));
		// first packet has no previous arrival
		send_item(item_of(FUNC_PACKET, 8'd3, 48'd1000, 48'd900));
		send_item(item_of(FUNC_PACKET, 8'd4, 48'd2010, 48'd1900));
		send_item(item_of(FUNC_PACKET, 8'd5, 48'd2990, 48'd2800));
		send_item(item_of(FUNC_REPORT, 8'd9, 48'd3000, 48'd77));
		send_item(item_of(FUNC_REPORT, 8'd0, 48'd1000, 48'd0));
		send_item(item_of(FUNC_REPORT, 8'd0, 48'd10, 48'd0));
		// wide differences saturate
		send_item(item_of(FUNC_PACKET, 8'd255, 48'hFFFF_FFFF_FFFF, 48'd0));
		send_item(item_of(FUNC_PACKET, 8'd3, 48'd0, 48'hFFFF_FFFF_FFFF));
		send_item(item_of(FUNC_REPORT, 8'd255, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_item(item_of(FUNC_PACKET, 8'd1, 48'd3, 48'd2));
		send_item(item_of(FUNC_PACKET, 8'd2, 48'd5, 48'd5));
		send_item(item_of(FUNC_PACKET, 8'd3, 48'd1005, 48'd1005));
		// right at the limits, then one past
		send_item(item_of(FUNC_PACKET, 8'd128, 48'd2505, 48'd2005));
		send_item(item_of(FUNC_PACKET, 8'd200, 48'd3004, 48'd2503));
		send_item(item_of(FUNC_REPORT, 8'd0, 48'd3004, 48'd0));
		wait_drained();

		phase = 0;
		while (sent_count < TOTAL_ITEMS) begin
			case (phase)
				0: set_config(16'd0, 16'd0, 7'd0, 7'd0, 16'd0);
				1: set_config(16'hFFFF, 16'hFFFF, 7'd100, 7'd100, 16'hFFFF);
				2: set_config(16'd500, 16'd500, 7'd1, 7'd1, 16'd1000);
				default: begin
					dl = ($urandom_range(0, 3) == 0) ? 16'($urandom())
						: 16'($urandom_range(200, 1500));
					il = ($urandom_range(0, 3) == 0) ? 16'($urandom())
						: 16'($urandom_range(200, 1500));
					ep = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 100))
						: 7'($urandom_range(0, 40));
					lp = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 100))
						: 7'($urandom_range(0, 10));
					np = ($urandom_range(0, 4) == 0) ? 16'($urandom())
						: 16'($urandom_range(500, 2000));
					set_config(dl, il, ep, lp, np);
				end
			endcase
			for (int s = 0; s < 3 && sent_count < TOTAL_ITEMS; s++)
				run_session($urandom_range(20, 80));
			wait_drained();
			phase++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
